@@ rtl/sbqm_pkg.sv @@
// Shared types and codes for the segmented byte queue manager.
// Request and result payloads, status and opcode codes, controller states and commands.
// No dependencies.
`default_nettype none
package sbqm_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_SEG = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [3:0] queue_id;
        logic [7:0] data_byte;
        logic       end_of_write;
    } t_request;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_data;
        logic       queue_empty;
        logic [6:0] free_segments;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic latch;
        logic exec;
        logic emit;
    } t_ctrl_cmd;

endpackage
`default_nettype wire

@@ rtl/sbqm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module sbqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ rtl/sbqm_ctrl.sv @@
// Controller state machine: accept, look up, execute, emit.
// Depends on sbqm_pkg.
`default_nettype none
module sbqm_ctrl
    import sbqm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output t_ctrl_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = i_start ? S_LOOK : S_IDLE;
            S_LOOK:  n_state = S_EXEC;
            S_EXEC:  n_state = S_EMIT;
            S_EMIT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.latch = i_start;
            end
            S_LOOK: begin
                o_cmd.busy = 1'b1;
            end
            S_EXEC: begin
                o_cmd.busy = 1'b1;
                o_cmd.exec = 1'b1;
            end
            S_EMIT: begin
                o_cmd.busy = 1'b1;
                o_cmd.emit = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/sbqm_datapath.sv @@
// Datapath: queue tables, free list pointers and the segment memories.
// Depends on sbqm_pkg and sbqm_ram.
`default_nettype none
module sbqm_datapath
    import sbqm_pkg::*;
#(
    parameter int NUM_QUEUES    = 16,
    parameter int NUM_SEGMENTS  = 64,
    parameter int SEGMENT_BYTES = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_ctrl_cmd i_cmd,
    input  wire t_request  i_req,
    output t_result        o_result
);

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int SW = $clog2(NUM_SEGMENTS);
    localparam int FW = $clog2(SEGMENT_BYTES + 1);
    localparam int PW = (SEGMENT_BYTES > 1) ? $clog2(SEGMENT_BYTES) : 1;
    localparam int BD = NUM_SEGMENTS * SEGMENT_BYTES;
    localparam int AW = $clog2(BD);
    localparam int CW = $clog2(NUM_SEGMENTS + 1);

    function automatic logic [3:0] fold_queue(logic [3:0] v);
        logic [7:0] acc;
        acc = {4'd0, v};
        for (int k = 3; k >= 0; k--) begin
            if (32'(acc) >= (NUM_QUEUES << k)) begin
                acc = acc - 8'(NUM_QUEUES << k);
            end
        end
        return acc[3:0];
    endfunction

    function automatic logic [SW-1:0] link_reset(logic [SW-1:0] s);
        return (32'(s) == NUM_SEGMENTS - 1) ? '0 : s + SW'(1);
    endfunction

    function automatic logic [AW-1:0] byte_addr(logic [SW-1:0] s, logic [PW-1:0] p);
        return AW'(s) * AW'(SEGMENT_BYTES) + AW'(p);
    endfunction

    t_request        r_item;
    logic [QW-1:0]   r_q;
    logic [SW-1:0]   r_qfirst [NUM_QUEUES];
    logic [SW-1:0]   r_qlast  [NUM_QUEUES];
    logic [NUM_QUEUES-1:0]   r_qbusy, r_wopen;
    logic [NUM_SEGMENTS-1:0] r_link_valid;
    logic            r_link_hit;
    logic [SW-1:0]   r_link_raddr;
    logic [SW-1:0]   r_free_first, r_free_last;
    logic [CW-1:0]   r_free_count;
    logic [1:0]      r_status;
    logic            r_rd_ok;

    logic [FW-1:0]   fill_rd, rpos_rd;
    logic [SW-1:0]   link_rd, link_val;
    logic [7:0]      byte_rd;
    logic [SW-1:0]   qf, ql, link_raddr;

    logic            fill_we, rpos_we, link_we, byte_we;
    logic [SW-1:0]   fill_wa, rpos_wa, link_wa, link_wd;
    logic [FW-1:0]   fill_wd, rpos_wd;
    logic [AW-1:0]   byte_wa, byte_ra;

    logic            is_wr, need_new, take, release_seg, drained;
    logic [FW-1:0]   rp1;
    logic [SW-1:0]   s_tgt;
    logic [PW-1:0]   pos;

    assign qf         = r_qfirst[r_q];
    assign ql         = r_qlast[r_q];
    assign link_raddr = (r_item.opcode == OP_WRITE) ? r_free_first : qf;
    assign link_val   = r_link_hit ? link_rd : link_reset(r_link_raddr);

    always_comb begin
        is_wr       = (r_item.opcode == OP_WRITE);
        need_new    = !r_wopen[r_q] || !r_qbusy[r_q] || (fill_rd >= FW'(SEGMENT_BYTES));
        take        = is_wr && need_new && (r_free_count != '0);
        rp1         = rpos_rd + FW'(1);
        drained     = (rp1 >= fill_rd);
        release_seg = !is_wr && r_qbusy[r_q] && drained;
        s_tgt       = take ? r_free_first : ql;
        pos         = take ? '0 : fill_rd[PW-1:0];

        byte_we = i_cmd.exec && is_wr && (take || !need_new);
        byte_wa = byte_addr(s_tgt, pos);
        byte_ra = byte_addr(qf, rpos_rd[PW-1:0]);

        fill_we = byte_we;
        fill_wa = s_tgt;
        fill_wd = take ? FW'(1) : fill_rd + FW'(1);

        rpos_we = i_cmd.exec && (take || (!is_wr && r_qbusy[r_q]));
        rpos_wa = take ? r_free_first : qf;
        rpos_wd = take ? '0 : rp1;

        link_we = i_cmd.exec && ((take && r_qbusy[r_q]) ||
                                 (release_seg && (r_free_count != '0)));
        link_wa = is_wr ? ql : r_free_last;
        link_wd = is_wr ? r_free_first : qf;
    end

    always_ff @(posedge i_clk) begin
        r_link_hit   <= r_link_valid[link_raddr];
        r_link_raddr <= link_raddr;
        if (i_cmd.latch) begin
            r_item <= i_req;
            r_q    <= QW'(fold_queue(i_req.queue_id));
        end
        if (i_cmd.exec) begin
            if (take) begin
                if (!r_qbusy[r_q]) begin
                    r_qfirst[r_q] <= r_free_first;
                end
                r_qlast[r_q] <= r_free_first;
            end
            if (release_seg && (qf != ql)) begin
                r_qfirst[r_q] <= link_val;
            end
            r_rd_ok  <= !is_wr && r_qbusy[r_q];
            r_status <= is_wr ? ((need_new && !take) ? ST_NO_SEG : ST_OK)
                              : (r_qbusy[r_q] ? ST_OK : ST_EMPTY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qbusy      <= '0;
            r_wopen      <= '0;
            r_link_valid <= '0;
            r_free_first <= '0;
            r_free_last  <= SW'(NUM_SEGMENTS - 1);
            r_free_count <= CW'(NUM_SEGMENTS);
        end else if (i_cmd.exec) begin
            if (link_we) begin
                r_link_valid[link_wa] <= 1'b1;
            end
            if (take) begin
                r_qbusy[r_q]  <= 1'b1;
                r_wopen[r_q]  <= 1'b1;
                r_free_first  <= link_val;
                r_free_count  <= r_free_count - CW'(1);
            end
            if (is_wr && r_item.end_of_write) begin
                r_wopen[r_q] <= 1'b0;
            end
            if (release_seg) begin
                if (qf == ql) begin
                    r_qbusy[r_q] <= 1'b0;
                    r_wopen[r_q] <= 1'b0;
                end
                if (r_free_count == '0) begin
                    r_free_first <= qf;
                end
                r_free_last  <= qf;
                r_free_count <= r_free_count + CW'(1);
            end
        end
    end

    sbqm_ram #(.WIDTH(8), .DEPTH(BD)) u_bytes (
        .i_clk(i_clk), .i_we(byte_we), .i_waddr(byte_wa), .i_wdata(r_item.data_byte),
        .i_raddr(byte_ra), .o_rdata(byte_rd)
    );

    sbqm_ram #(.WIDTH(FW), .DEPTH(NUM_SEGMENTS)) u_fill (
        .i_clk(i_clk), .i_we(fill_we), .i_waddr(fill_wa), .i_wdata(fill_wd),
        .i_raddr(is_wr ? ql : qf), .o_rdata(fill_rd)
    );

    sbqm_ram #(.WIDTH(FW), .DEPTH(NUM_SEGMENTS)) u_rpos (
        .i_clk(i_clk), .i_we(rpos_we), .i_waddr(rpos_wa), .i_wdata(rpos_wd),
        .i_raddr(qf), .o_rdata(rpos_rd)
    );

    sbqm_ram #(.WIDTH(SW), .DEPTH(NUM_SEGMENTS)) u_link (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_wa), .i_wdata(link_wd),
        .i_raddr(link_raddr), .o_rdata(link_rd)
    );

    always_comb begin
        o_result.status        = r_status;
        o_result.read_data     = r_rd_ok ? byte_rd : 8'd0;
        o_result.queue_empty   = !r_qbusy[r_q];
        o_result.free_segments = 7'(r_free_count);
    end

endmodule
`default_nettype wire

@@ rtl/segmented_byte_queue_manager.sv @@
// Top level of the segmented byte queue manager: controller plus datapath.
// Depends on sbqm_pkg, sbqm_ctrl, sbqm_datapath, sbqm_ram.
//
// Usage: present a request on i_req and raise start while busy is low; the
// request is taken at that clock edge. Queues share a pool of segments held
// on a first-in, first-out free list; writes append to the queue's open tail
// segment, reads take the oldest byte and return emptied segments to the pool.
// Exactly one result per request appears on o_result for one cycle, marked by
// o_strobe, after the lookup and execute steps; busy drops in the next cycle.
// A request passes in order through accept, pointer and counter lookup in the
// segment memories, read-modify-write of pointers with the data byte access,
// and result. The receiver cannot stall; the result must be taken when shown.
// After reset all segments are on the free list in index order, every queue is
// empty, and the block is ready at once.
// Status: ok, no free segment (byte dropped), or queue empty on read.
`default_nettype none
module segmented_byte_queue_manager
    import sbqm_pkg::*;
#(
    parameter int NUM_QUEUES    = 16,
    parameter int NUM_SEGMENTS  = 64,
    parameter int SEGMENT_BYTES = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_request i_req,
    output logic          o_strobe,
    output t_result       o_result
);

    t_ctrl_cmd cmd;

    sbqm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_cmd(cmd)
    );

    sbqm_datapath #(
        .NUM_QUEUES(NUM_QUEUES), .NUM_SEGMENTS(NUM_SEGMENTS), .SEGMENT_BYTES(SEGMENT_BYTES)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_req(i_req), .o_result(o_result)
    );

    assign busy     = cmd.busy;
    assign o_strobe = cmd.emit;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 (!o_strobe ##1 o_strobe))
        else $error("result not shown three cycles after request");

    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !busy)
        else $error("busy held after result");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.status == ST_OK || o_result.status == ST_NO_SEG ||
                      o_result.status == ST_EMPTY))
        else $error("invalid status code");

    a_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_OK) |-> (o_result.read_data == 8'd0))
        else $error("read data on failed request");

endmodule
`default_nettype wire

@@ test/segmented_byte_queue_manager_test.sv @@
// Self-checking testbench for the segmented byte queue manager.
// Predicts each result from its own model of the queues and segment free list.
// Depends on sbqm_pkg and segmented_byte_queue_manager.
`default_nettype none
module segmented_byte_queue_manager_test;
    import sbqm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NQ = 16;
    localparam int NS = 64;
    localparam int SB = 64;
    localparam int CYCLE_LIMIT = 200000;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_request i_req;
    logic     o_strobe;
    t_result  o_result;

    segmented_byte_queue_manager i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_strobe(o_strobe), .o_result(o_result)
    );

    logic [7:0] seg_data [NS][SB];
    logic [5:0] seg_next [NS];
    int         seg_fill [NS];
    int         seg_rpos [NS];
    logic [5:0] q_head [NQ];
    logic [5:0] q_tail [NQ];
    bit         q_busy [NQ];
    bit         q_open [NQ];
    logic [5:0] pool_head;
    logic [5:0] pool_tail;
    int         pool_count;

    t_request pending_reqs[$];
    t_result  expected_results[$];
    int       mismatches;
    int       cycles;
    int       n_writes, n_reads, n_drops, n_empty_reads;
    bit       drive_idle;
    bit       hold_for_drain;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
        mismatches++;
    endtask

    function automatic void reset_pool();
        for (int s = 0; s < NS; s++) begin
            seg_next[s] = 6'((s + 1) % NS);
            seg_fill[s] = 0;
            seg_rpos[s] = 0;
        end
        for (int q = 0; q < NQ; q++) begin
            q_busy[q] = 1'b0;
            q_open[q] = 1'b0;
        end
        pool_head = '0;
        pool_tail = 6'(NS - 1);
        pool_count = NS;
    endfunction

    function automatic t_result apply_request(t_request r);
        t_result    res;
        int         q;
        logic [5:0] s;
        bit         need_seg;
        bit         stored;
        q = r.queue_id;
        res = '0;
        res.status = ST_OK;
        if (r.opcode == OP_WRITE) begin
            need_seg = !q_open[q] || !q_busy[q] || seg_fill[q_tail[q]] >= SB;
            stored = 1'b1;
            if (need_seg) begin
                if (pool_count == 0) begin
                    res.status = ST_NO_SEG;
                    stored = 1'b0;
                end else begin
                    s = pool_head;
                    pool_head = seg_next[s];
                    pool_count--;
                    seg_fill[s] = 0;
                    seg_rpos[s] = 0;
                    if (q_busy[q]) seg_next[q_tail[q]] = s;
                    else begin
                        q_head[q] = s;
                        q_busy[q] = 1'b1;
                    end
                    q_tail[q] = s;
                    q_open[q] = 1'b1;
                end
            end
            if (stored) begin
                s = q_tail[q];
                seg_data[s][seg_fill[s]] = r.data_byte;
                seg_fill[s]++;
            end
            if (r.end_of_write) q_open[q] = 1'b0;
        end else if (!q_busy[q]) begin
            res.status = ST_EMPTY;
        end else begin
            s = q_head[q];
            res.read_data = seg_data[s][seg_rpos[s]];
            seg_rpos[s]++;
            if (seg_rpos[s] >= seg_fill[s]) begin
                if (s == q_tail[q]) begin
                    q_busy[q] = 1'b0;
                    q_open[q] = 1'b0;
                end else q_head[q] = seg_next[s];
                if (pool_count == 0) pool_head = s;
                else seg_next[pool_tail] = s;
                pool_tail = s;
                pool_count++;
            end
        end
        res.queue_empty = !q_busy[q];
        res.free_segments = 7'(pool_count);
        return res;
    endfunction

    function automatic t_request make_req(logic op, int q, int d, logic eow);
        t_request r;
        r.opcode = op;
        r.queue_id = 4'(q);
        r.data_byte = 8'(d);
        r.end_of_write = eow;
        return r;
    endfunction

    // Driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            start <= 1'b0;
        end else if (!start && !hold_for_drain && pending_reqs.size() > 0 &&
                     !(drive_idle && $urandom_range(99) < 19)) begin
            i_req <= pending_reqs[0];
            start <= 1'b1;
        end
    end

    // Accept and monitor
    always @(posedge i_clk) begin
        t_result want;
        t_request r;
        if (i_rst_n) begin
            cycles++;
            if (start && !busy) begin
                r = pending_reqs.pop_front();
                expected_results.push_back(apply_request(r));
                if (r.opcode == OP_WRITE) n_writes++;
                else n_reads++;
            end
            if (o_strobe) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.status !== want.status)
                        report("status", o_result.status, want.status);
                    if (o_result.read_data !== want.read_data)
                        report("read_data", o_result.read_data, want.read_data);
                    if (o_result.queue_empty !== want.queue_empty)
                        report("queue_empty", o_result.queue_empty, want.queue_empty);
                    if (o_result.free_segments !== want.free_segments)
                        report("free_segments", o_result.free_segments,
                               want.free_segments);
                    if (want.status == ST_NO_SEG) n_drops++;
                    if (want.status == ST_EMPTY) n_empty_reads++;
                end
            end
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        wait (pending_reqs.size() == 0 && !start);
        @(posedge i_clk);
        wait (expected_results.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_burst(int q, int len);
        for (int i = 0; i < len; i++)
            pending_reqs.push_back(make_req(OP_WRITE, q, $urandom_range(255), i == len - 1));
    endtask

    initial begin
        int q, len, op_sel;
        start = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        drive_idle = 1'b1;
        hold_for_drain = 1'b0;
        mismatches = 0;
        cycles = 0;
        reset_pool();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty reads, field extremes, full segment rollover.
        pending_reqs.push_back(make_req(OP_READ, 0, 8'hFF, 1'b1));
        pending_reqs.push_back(make_req(OP_READ, 15, 0, 1'b0));
        pending_reqs.push_back(make_req(OP_WRITE, 15, 8'hFF, 1'b0));
        pending_reqs.push_back(make_req(OP_WRITE, 15, 8'h00, 1'b1));
        pending_reqs.push_back(make_req(OP_WRITE, 15, 8'hA5, 1'b1));
        pending_reqs.push_back(make_req(OP_WRITE, 0, 8'h5A, 1'b0));
        for (int i = 0; i < 4; i++) pending_reqs.push_back(make_req(OP_READ, 15, 0, 1'b0));
        pending_reqs.push_back(make_req(OP_READ, 0, 8'hFF, 1'b1));
        pending_reqs.push_back(make_req(OP_READ, 0, 0, 1'b0));
        write_burst(3, SB + 2);
        for (int i = 0; i < SB + 2; i++)
            pending_reqs.push_back(make_req(OP_READ, 3, 0, 1'b0));
        wait_drained();

        // Exhaust the pool with single-byte closed writes, then overflow.
        drive_idle = 1'b0;
        for (int i = 0; i < NS + 3; i++)
            pending_reqs.push_back(make_req(OP_WRITE, i % NQ, i, 1'b1));
        pending_reqs.push_back(make_req(OP_WRITE, 7, 8'h3C, 1'b0));
        for (int i = 0; i < NS + 3; i++)
            pending_reqs.push_back(make_req(OP_READ, i % NQ, 0, 1'b0));
        wait_drained();
        drive_idle = 1'b1;

        // Random: write bursts and reads, mostly on few queues.
        for (int blk = 0; blk < 50; blk++) begin
            if (blk == 15) begin
                wait (pending_reqs.size() == 0);
                drive_idle = 1'b0;
            end
            if (blk == 30) begin
                wait (pending_reqs.size() == 0);
                drive_idle = 1'b1;
            end
            if (blk == 40) begin
                wait (pending_reqs.size() == 0);
                hold_for_drain = 1'b1;
                wait (expected_results.size() == 0);
                @(negedge i_clk);
                hold_for_drain = 1'b0;
            end
            q = $urandom_range(99) < 70 ? $urandom_range(3) : $urandom_range(NQ - 1);
            op_sel = $urandom_range(99);
            if (op_sel < 45) begin
                len = $urandom_range(99) < 85 ? $urandom_range(1, 6) : $urandom_range(30, 70);
                write_burst(q, len);
            end else if (op_sel < 85) begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    pending_reqs.push_back(make_req(OP_READ, q, $urandom_range(255),
                                                    1'($urandom_range(1))));
            end else begin
                pending_reqs.push_back(make_req(1'($urandom_range(1)), $urandom_range(NQ - 1),
                                                $urandom_range(255), 1'($urandom_range(1))));
            end
        end
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("covered %0d writes, %0d reads, %0d drops on empty pool, %0d empty reads",
                 n_writes, n_reads, n_drops, n_empty_reads);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
